>>> src/kruf_pkg.sv
// ----------------------------------------------------------------------------
// kruf_pkg
// Shared types and constants of the union-find edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kruf_pkg;

	localparam int NODES  = 1024;
	localparam int ADDR_W = $clog2(NODES);

	localparam int NODE_W = 10;
	localparam int COST_W = 16;
	localparam int SUM_W  = 26;
	localparam int CNT_W  = 10;
	localparam int RANK_W = 4;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [RANK_W-1:0] RANK_MAX  = '1;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [ADDR_W-1:0] parent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND_A,
		S_FIND_B,
		S_JOIN,
		S_BUMP,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

>>> src/kruf_edge_if.sv
// ----------------------------------------------------------------------------
// kruf_edge_if
// Edge channel: two endpoints, signed cost and end-of-run mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface kruf_edge_if;

	logic                                valid;
	logic                                ready;
	logic [kruf_pkg::NODE_W-1:0]         node_a;
	logic [kruf_pkg::NODE_W-1:0]         node_b;
	logic signed [kruf_pkg::COST_W-1:0]  edge_cost;
	logic                                last_edge;

	modport source (output valid, node_a, node_b, edge_cost, last_edge, input ready);
	modport sink   (input valid, node_a, node_b, edge_cost, last_edge, output ready);

endinterface

`default_nettype wire

>>> src/kruf_result_if.sv
// ----------------------------------------------------------------------------
// kruf_result_if
// Result channel: accept flag, endpoint echo, running total and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface kruf_result_if;

	logic                               valid;
	logic                               ready;
	logic                               accepted;
	logic [kruf_pkg::NODE_W-1:0]        end_a;
	logic [kruf_pkg::NODE_W-1:0]        end_b;
	logic signed [kruf_pkg::SUM_W-1:0]  total_cost;
	logic [kruf_pkg::CNT_W-1:0]         tree_edges;
	logic                               run_done;

	modport source (output valid, accepted, end_a, end_b, total_cost, tree_edges, run_done,
		input ready);
	modport sink   (input valid, accepted, end_a, end_b, total_cost, tree_edges, run_done,
		output ready);

endinterface

`default_nettype wire

>>> src/kruf_ram.sv
// ----------------------------------------------------------------------------
// kruf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kruf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/kruskal_union_find_edge_filter.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Spanning-forest edge filter over a parent/rank memory, union by rank.
// With union by rank a tree is at most log2(NODES) deep. The pointer walk
// uses the single memory read port. A new edge word is taken only once the
// result of the last one has been loaded into the output register.
// A result waits in an output register.
// Reset and every last-marked word start a clearing pass of all NODES entries.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_filter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	kruf_edge_if.sink     edges,
	kruf_result_if.source results
);

	localparam logic [kruf_pkg::ADDR_W-1:0] LAST_ADDR = kruf_pkg::ADDR_W'(kruf_pkg::NODES - 1);

	kruf_pkg::state_t state_q;
	kruf_pkg::state_t state_d;

	logic                               ram_we;
	logic [kruf_pkg::ADDR_W-1:0]        ram_waddr;
	kruf_pkg::entry_t                   ram_wdata;
	logic [kruf_pkg::ADDR_W-1:0]        ram_raddr;
	logic [kruf_pkg::ENTRY_W-1:0]       ram_rdata;
	kruf_pkg::entry_t                   rd_entry;

	logic [kruf_pkg::NODE_W-1:0]        a_q;
	logic [kruf_pkg::NODE_W-1:0]        b_q;
	logic signed [kruf_pkg::COST_W-1:0] cost_q;
	logic                               last_q;
	logic [kruf_pkg::ADDR_W-1:0]        cur_q;
	logic [kruf_pkg::ADDR_W-1:0]        ra_q;
	logic [kruf_pkg::ADDR_W-1:0]        rb_q;
	logic [kruf_pkg::RANK_W-1:0]        rank_a_q;
	logic [kruf_pkg::RANK_W-1:0]        rank_b_q;
	logic                               ok_q;
	logic signed [kruf_pkg::SUM_W-1:0]  sum_q;
	logic [kruf_pkg::CNT_W-1:0]         cnt_q;
	logic [kruf_pkg::ADDR_W-1:0]        clr_q;

	logic                               out_valid_q;
	logic                               out_accepted_q;
	logic [kruf_pkg::NODE_W-1:0]        out_end_a_q;
	logic [kruf_pkg::NODE_W-1:0]        out_end_b_q;
	logic signed [kruf_pkg::SUM_W-1:0]  out_total_q;
	logic [kruf_pkg::CNT_W-1:0]         out_count_q;
	logic                               out_done_q;

	logic                               in_range;
	logic                               at_root;
	logic                               out_load;
	logic signed [kruf_pkg::SUM_W:0]    sum_wide;
	logic signed [kruf_pkg::SUM_W-1:0]  sum_sat;
	logic [kruf_pkg::RANK_W-1:0]        rank_b_inc;

	kruf_ram #(
		.WIDTH (kruf_pkg::ENTRY_W),
		.DEPTH (kruf_pkg::NODES)
	) u_forest_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = kruf_pkg::entry_t'(ram_rdata);

	assign in_range = (32'(edges.node_a) < kruf_pkg::NODES) &&
		(32'(edges.node_b) < kruf_pkg::NODES);

	assign at_root = (rd_entry.parent == cur_q) || (32'(rd_entry.parent) >= kruf_pkg::NODES);

	// saturating running total
	assign sum_wide = (kruf_pkg::SUM_W+1)'(sum_q) + (kruf_pkg::SUM_W+1)'(cost_q);
	always_comb begin
		if (sum_wide[kruf_pkg::SUM_W] != sum_wide[kruf_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[kruf_pkg::SUM_W] ? {1'b1, {(kruf_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(kruf_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[kruf_pkg::SUM_W-1:0];
		end
	end

	assign rank_b_inc = (rank_b_q == kruf_pkg::RANK_MAX) ? rank_b_q : rank_b_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kruf_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edges.ready  = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = clr_q;
		ram_wdata    = '{rank: '0, parent: clr_q};
		ram_raddr    = cur_q;
		out_load     = 1'b0;
		case (state_q)
			kruf_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = kruf_pkg::S_IDLE;
				end
			end
			kruf_pkg::S_IDLE: begin
				edges.ready = 1'b1;
				ram_raddr   = kruf_pkg::ADDR_W'(edges.node_a);
				if (edges.valid) begin
					state_d = in_range ? kruf_pkg::S_FIND_A : kruf_pkg::S_EMIT;
				end
			end
			kruf_pkg::S_FIND_A: begin
				if (at_root) begin
					ram_raddr = kruf_pkg::ADDR_W'(b_q);
					state_d   = kruf_pkg::S_FIND_B;
				end else begin
					ram_raddr = rd_entry.parent;
				end
			end
			kruf_pkg::S_FIND_B: begin
				ram_raddr = rd_entry.parent;
				if (at_root) begin
					state_d = kruf_pkg::S_JOIN;
				end
			end
			kruf_pkg::S_JOIN: begin
				state_d = kruf_pkg::S_EMIT;
				if (ra_q != rb_q) begin
					ram_we = 1'b1;
					if (rank_a_q > rank_b_q) begin
						ram_waddr = rb_q;
						ram_wdata = '{rank: rank_b_q, parent: ra_q};
					end else begin
						ram_waddr = ra_q;
						ram_wdata = '{rank: rank_a_q, parent: rb_q};
						if (rank_a_q == rank_b_q) begin
							state_d = kruf_pkg::S_BUMP;
						end
					end
				end
			end
			kruf_pkg::S_BUMP: begin
				ram_we    = 1'b1;
				ram_waddr = rb_q;
				ram_wdata = '{rank: rank_b_inc, parent: rb_q};
				state_d   = kruf_pkg::S_EMIT;
			end
			kruf_pkg::S_EMIT: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = last_q ? kruf_pkg::S_CLEAR : kruf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kruf_pkg::S_CLEAR;
			end
		endcase
	end

	// control and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			ok_q  <= 1'b0;
		end else begin
			case (state_q)
				kruf_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				kruf_pkg::S_IDLE: begin
					ok_q <= 1'b0;
				end
				kruf_pkg::S_JOIN: begin
					if (ra_q != rb_q) begin
						ok_q  <= 1'b1;
						sum_q <= sum_sat;
						if (cnt_q != kruf_pkg::COUNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				kruf_pkg::S_EMIT: begin
					if (out_load && last_q) begin
						clr_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// word capture and pointer walk
	always_ff @(posedge clk) begin
		case (state_q)
			kruf_pkg::S_IDLE: begin
				if (edges.valid) begin
					a_q    <= edges.node_a;
					b_q    <= edges.node_b;
					cost_q <= edges.edge_cost;
					last_q <= edges.last_edge;
					cur_q  <= kruf_pkg::ADDR_W'(edges.node_a);
				end
			end
			kruf_pkg::S_FIND_A: begin
				if (at_root) begin
					ra_q     <= cur_q;
					rank_a_q <= rd_entry.rank;
					cur_q    <= kruf_pkg::ADDR_W'(b_q);
				end else begin
					cur_q <= rd_entry.parent;
				end
			end
			kruf_pkg::S_FIND_B: begin
				if (at_root) begin
					rb_q     <= cur_q;
					rank_b_q <= rd_entry.rank;
				end else begin
					cur_q <= rd_entry.parent;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_accepted_q <= ok_q;
			out_end_a_q    <= a_q;
			out_end_b_q    <= b_q;
			out_total_q    <= sum_q;
			out_count_q    <= cnt_q;
			out_done_q     <= last_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.accepted   = out_accepted_q;
	assign results.end_a      = out_end_a_q;
	assign results.end_b      = out_end_b_q;
	assign results.total_cost = out_total_q;
	assign results.tree_edges = out_count_q;
	assign results.run_done   = out_done_q;

endmodule

`default_nettype wire

>>> tb/sv/kruskal_union_find_edge_filter_test.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_test
// Self-checking bench for the union-find edge filter. A short directed table
// covers extremes, self loops, rank ties and end of run. It is followed by
// sorted edge runs, full binary-merge forests and unsorted noise. Every result
// word is scored against a known table entry or a behavioral forest model,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_filter_test;

	timeunit 1ns;
	timeprecision 1ps;

	import kruf_pkg::*;

	localparam int RANDOM_EDGES = 1000;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 64;
	localparam int MAX_WAIT     = 8;
	localparam int SUM_HI       = 2 ** (SUM_W - 1) - 1;
	localparam int SUM_LO       = -(2 ** (SUM_W - 1));
	localparam int COST_HI      = 2 ** (COST_W - 1) - 1;
	localparam int COST_LO      = -(2 ** (COST_W - 1));

	typedef struct packed {
		logic [NODE_W-1:0]        node_a;
		logic [NODE_W-1:0]        node_b;
		logic signed [COST_W-1:0] edge_cost;
		logic                     last_edge;
	} edge_word_t;

	typedef struct packed {
		logic                     accepted;
		logic [NODE_W-1:0]        end_a;
		logic [NODE_W-1:0]        end_b;
		logic signed [SUM_W-1:0]  total_cost;
		logic [CNT_W-1:0]         tree_edges;
		logic                     run_done;
	} tree_result_t;

	typedef struct {
		edge_word_t   word;
		bit           known;
		tree_result_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	kruf_edge_if   edges_if ();
	kruf_result_if results_if ();

	kruskal_union_find_edge_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.edges   (edges_if),
		.results (results_if)
	);

	int                forest_parent [NODES];
	logic [RANK_W-1:0] forest_rank [NODES];
	int                run_total;
	int                run_count;
	tree_result_t      pending_results [$];
	table_row_t        directed_rows [$];
	bit                calm = 1'b0;
	int                err_count = 0;
	int                edges_sent = 0;
	int                runs_sent = 0;
	int                joins_seen = 0;
	int                deepest_walk = 0;
	int                cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_forest();
		int k;
		for (k = 0; k < NODES; k++) begin
			forest_parent[k] = k;
			forest_rank[k]   = '0;
		end
		run_total = 0;
		run_count = 0;
	endfunction

	function automatic int find_root(input int node);
		int up;
		int steps;
		int k;
		steps = 0;
		for (k = 0; k < NODES; k++) begin
			up = forest_parent[node];
			if (up == node || up >= NODES)
				break;
			node = up;
			steps++;
		end
		if (steps > deepest_walk)
			deepest_walk = steps;
		return node;
	endfunction

	function automatic tree_result_t filter_edge(input edge_word_t w);
		tree_result_t r;
		int root_a;
		int root_b;
		int sum;
		r.accepted = 1'b0;
		if (int'(w.node_a) < NODES && int'(w.node_b) < NODES) begin
			root_a = find_root(int'(w.node_a));
			root_b = find_root(int'(w.node_b));
			if (root_a != root_b) begin
				if (forest_rank[root_a] < forest_rank[root_b]) begin
					forest_parent[root_a] = root_b;
				end else if (forest_rank[root_a] > forest_rank[root_b]) begin
					forest_parent[root_b] = root_a;
				end else begin
					forest_parent[root_a] = root_b;
					if (forest_rank[root_b] < RANK_MAX)
						forest_rank[root_b] = forest_rank[root_b] + 1'b1;
				end
				sum = run_total + int'($signed(w.edge_cost));
				if (sum > SUM_HI)
					sum = SUM_HI;
				if (sum < SUM_LO)
					sum = SUM_LO;
				run_total = sum;
				if (run_count < int'(COUNT_MAX))
					run_count++;
				r.accepted = 1'b1;
				joins_seen++;
			end
		end
		r.end_a      = w.node_a;
		r.end_b      = w.node_b;
		r.total_cost = run_total[SUM_W-1:0];
		r.tree_edges = run_count[CNT_W-1:0];
		r.run_done   = w.last_edge;
		// forest clears after the last word of a run
		if (w.last_edge)
			clear_forest();
		return r;
	endfunction

	function automatic void check_result(input tree_result_t want, input tree_result_t got);
		if (got.accepted !== want.accepted) begin
			$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
			err_count++;
		end
		if (got.end_a !== want.end_a) begin
			$error("end_a: expected %0d, got %0d", want.end_a, got.end_a);
			err_count++;
		end
		if (got.end_b !== want.end_b) begin
			$error("end_b: expected %0d, got %0d", want.end_b, got.end_b);
			err_count++;
		end
		if (got.total_cost !== want.total_cost) begin
			$error("total_cost: expected %0d, got %0d", want.total_cost, got.total_cost);
			err_count++;
		end
		if (got.tree_edges !== want.tree_edges) begin
			$error("tree_edges: expected %0d, got %0d", want.tree_edges, got.tree_edges);
			err_count++;
		end
		if (got.run_done !== want.run_done) begin
			$error("run_done: expected %0d, got %0d", want.run_done, got.run_done);
			err_count++;
		end
	endfunction

	function automatic edge_word_t make_word(input int a, input int b, input int cost,
		input bit last);
		edge_word_t w;
		w.node_a    = a[NODE_W-1:0];
		w.node_b    = b[NODE_W-1:0];
		w.edge_cost = cost[COST_W-1:0];
		w.last_edge = last;
		return w;
	endfunction

	function automatic void add_row(input edge_word_t w);
		table_row_t row;
		row.word  = w;
		row.known = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_known(input edge_word_t w, input bit acc, input int tot,
		input int cnt);
		table_row_t row;
		row.word            = w;
		row.known           = 1'b1;
		row.want.accepted   = acc;
		row.want.end_a      = w.node_a;
		row.want.end_b      = w.node_b;
		row.want.total_cost = tot[SUM_W-1:0];
		row.want.tree_edges = cnt[CNT_W-1:0];
		row.want.run_done   = w.last_edge;
		directed_rows.push_back(row);
	endfunction

	function automatic int pick_wait();
		return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic int random_cost();
		return int'($urandom_range(0, 65535)) + COST_LO;
	endfunction

	function automatic int next_cost(input int cost);
		int c;
		c = cost + int'($urandom_range(0, 3000));
		return (c > COST_HI) ? COST_HI : c;
	endfunction

	task automatic drive_edge(input table_row_t row);
		int gap;
		tree_result_t predicted;
		gap = pick_wait();
		if (gap > 0) begin
			edges_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edges_if.valid     <= 1'b1;
		edges_if.node_a    <= row.word.node_a;
		edges_if.node_b    <= row.word.node_b;
		edges_if.edge_cost <= row.word.edge_cost;
		edges_if.last_edge <= row.word.last_edge;
		do
			@(posedge clk);
		while (edges_if.ready !== 1'b1);
		predicted = filter_edge(row.word);
		pending_results.push_back(row.known ? row.want : predicted);
		edges_sent++;
		if (row.word.last_edge)
			runs_sent++;
	endtask

	task automatic send_edge(input edge_word_t w);
		table_row_t row;
		row.word  = w;
		row.known = 1'b0;
		row.want  = '0;
		drive_edge(row);
	endtask

	task automatic drain_results();
		edges_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// pairwise merges of equal-rank trees, giving the deepest walks
	task automatic run_merge_forest(input int order, input int first_cost);
		int mask;
		int cost;
		int span;
		int i;
		int a;
		int b;
		mask = $urandom_range(0, NODES - 1);
		cost = first_cost;
		for (span = 1; span < (1 << order); span = span * 2) begin
			for (i = 0; i < (1 << order); i += 2 * span) begin
				a = i ^ mask;
				b = (i + span) ^ mask;
				if ($urandom_range(0, 1))
					{a, b} = {b, a};
				send_edge(make_word(a, b, cost, 1'b0));
				cost = next_cost(cost);
				if (span > 1 && $urandom_range(0, 7) == 0) begin
					send_edge(make_word(i ^ mask, (i + span - 1) ^ mask, cost, 1'b0));
					cost = next_cost(cost);
				end
			end
		end
		send_edge(make_word(mask, mask ^ ((1 << order) - 1), cost, 1'b1));
	endtask

	task automatic run_edge_batch(input int spread, input int count, input bit sorted);
		int base;
		int cost;
		int k;
		base = $urandom_range(0, NODES - 1);
		cost = random_cost();
		for (k = 0; k < count; k++) begin
			send_edge(make_word(base + int'($urandom_range(0, spread)),
				base + int'($urandom_range(0, spread)), cost, k == count - 1));
			cost = sorted ? next_cost(cost) : random_cost();
		end
	endtask

	initial begin
		int pick;
		arst_n             <= 1'b0;
		edges_if.valid     <= 1'b0;
		edges_if.node_a    <= '0;
		edges_if.node_b    <= '0;
		edges_if.edge_cost <= '0;
		edges_if.last_edge <= 1'b0;
		clear_forest();

		add_known(make_word(0, 1023, COST_LO, 1'b0), 1'b1, COST_LO, 1);
		add_known(make_word(5, 5, -100, 1'b0), 1'b0, COST_LO, 1);
		add_known(make_word(1023, 0, -50, 1'b0), 1'b0, COST_LO, 1);
		add_row(make_word(1, 2, 0, 1'b0));
		add_row(make_word(3, 2, 10, 1'b0));
		add_row(make_word(2, 4, 20, 1'b0));
		add_row(make_word(0, 2, 30, 1'b0));
		add_row(make_word(1, 1023, 40, 1'b0));
		add_row(make_word(6, 7, 50, 1'b0));
		add_row(make_word(8, 9, 60, 1'b0));
		add_row(make_word(7, 9, 70, 1'b0));
		add_row(make_word(3, 8, 80, 1'b0));
		add_row(make_word(4, 6, 90, 1'b0));
		add_row(make_word(512, 511, COST_HI, 1'b1));
		add_known(make_word(0, 1023, COST_HI, 1'b0), 1'b1, COST_HI, 1);
		add_known(make_word(1023, 0, COST_HI, 1'b1), 1'b0, COST_HI, 1);
		add_known(make_word(1023, 1023, 0, 1'b1), 1'b0, 0, 0);
		add_row(make_word('h2AA, 'h155, -1, 1'b0));
		add_row(make_word('h155, 'h3FF, 'h5555, 1'b0));
		add_row(make_word('h2AA, 'h3FF, -21846, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			drive_edge(directed_rows[k]);
		drain_results();

		run_merge_forest(9, 30000);
		while (edges_sent < directed_rows.size() + RANDOM_EDGES) begin
			calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				run_merge_forest($urandom_range(2, 6), random_cost());
			end else if (pick < 8) begin
				run_edge_batch($urandom_range(1, 48), $urandom_range(4, 60), 1'b1);
			end else begin
				run_edge_batch(NODES - 1, $urandom_range(1, 20), 1'b0);
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end
		calm = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d edge words in %0d graph runs, %0d joins, deepest walk %0d links",
			edges_sent, runs_sent, joins_seen, deepest_walk);
		$display("summary: %0d cycles, %0d mismatches", cycle_count, err_count);
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		tree_result_t got;
		tree_result_t want;
		int stall;
		results_if.ready <= 1'b0;
		do
			@(posedge clk);
		while (arst_n !== 1'b1);
		forever begin
			stall = pick_wait();
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (results_if.valid !== 1'b1);
			got.accepted   = results_if.accepted;
			got.end_a      = results_if.end_a;
			got.end_b      = results_if.end_b;
			got.total_cost = results_if.total_cost;
			got.tree_edges = results_if.tree_edges;
			got.run_done   = results_if.run_done;
			if (pending_results.size() == 0) begin
				$error("result word with no edge pending: end_a %0d end_b %0d",
					got.end_a, got.end_b);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_result(want, got);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("no finish within %0d cycles, %0d words pending", CYCLE_LIMIT,
			pending_results.size());
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
